// ----- rtl/b3hs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, word types and arithmetic helpers of the 3x3 box filter block.
package b3hs_pkg;

  // Widest image row that the line store holds.
  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned LineDepth    = MaxWidth + 1;
  localparam int unsigned ColW         = $clog2(LineDepth);
  localparam int unsigned HeightLimit  = 4096;
  localparam int unsigned RowW         = 13;
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned PixW         = 8;
  localparam int unsigned SumW         = 12;

  localparam int unsigned ResetWidth   = (MaxWidth < 512) ? MaxWidth : 512;
  localparam int unsigned ResetHeight  = 512;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
    logic            is_padding;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0] gray_value;
    logic [PixW-1:0] mean_value;
    logic [PixW-1:0] highpass_value;
    logic [PixW-1:0] sharpen_value;
    logic            end_of_frame;
  } out_word_t;

  // One column of the 3x3 window, top row first.
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } win_col_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Division by three through a reciprocal; exact for sums up to 765.
  function automatic logic [PixW-1:0] div3(input logic [9:0] s);
    logic [19:0] p;
    p = {10'd0, s} * 20'd683;
    return p[18:11];
  endfunction

  // Division by nine through a reciprocal; exact for sums up to 2295.
  function automatic logic [PixW-1:0] div9(input logic [SumW-1:0] s);
    logic [23:0] p;
    p = {12'd0, s} * 24'd3641;
    return p[22:15];
  endfunction

endpackage

// ----- rtl/b3hs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module b3hs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/b3hs_cell.sv -----
`timescale 1ns / 1ps
// One column cell of the 3x3 window; on each shift it loads its neighbor's column, or zero when cleared.
module b3hs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b3hs_pkg::cell_ctrl_t ctrl_i,
  input  b3hs_pkg::win_col_t   col_i,
  output b3hs_pkg::win_col_t   col_o
);
  import b3hs_pkg::*;

  win_col_t col_q;
  win_col_t col_d;

  always_comb begin
    col_d = col_q;
    if (ctrl_i.shift) begin
      col_d = ctrl_i.clear ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ----- rtl/box3x3_highpass_sharpen_top.sv -----
`timescale 1ns / 1ps
// Top level of the streaming 3x3 box filter with high-pass and sharpen results.
//
// The block takes one BGR pixel word per clock while in_stall_o is low, in raster order
// over an extended grid of (frame_height+1) rows by (frame_width+1) columns, where the
// last column and the last row are padding words, and turns each pixel into gray as
// (blue+green+red)/3. A result word for image pixel (y,x) is produced by the input word
// at extended position (y+1,x+1), so words in extended row 0 or column 0 produce none.
// Each result carries the gray level of the window center, the zero-padded 3x3 mean,
// gray minus mean and twice gray minus mean, both wrapped to eight bits, and an
// end-of-frame flag on the frame's last pixel. A new word need not wait for earlier ones:
// the two line stores share a single RAM of MaxWidth+1 entries that is read once and
// written once per word, and the window is a chain of three column cells that shifts
// once per word. A result is registered after the line store read, in the window cells,
// as window sum and center pixel, and in the output register; the whole pipeline moves
// whenever the output register is empty or being taken, so input stall only follows
// output stall. Stored rows are masked by position, so there is no clearing pass after
// reset. Writing either configuration register restarts the frame; writes are expected
// only while the block is idle. A width of zero reads as one and a width above MaxWidth
// as MaxWidth; a height of zero reads as one and a height above 4096 as 4096.
module box3x3_highpass_sharpen_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Pixel input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  b3hs_pkg::in_word_t                 in_word_i,
  // Result output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output b3hs_pkg::out_word_t                out_word_o,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [b3hs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [b3hs_pkg::CfgDataW-1:0]      cfg_data_i
);
  import b3hs_pkg::*;

  // Effective frame size, already clamped into range when written.
  logic [ColW-1:0] width_q, width_d;
  logic [RowW-1:0] height_q, height_d;

  // Extended grid position of the next input word.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic adv;
  logic in_acc;
  logic cfg_wr;
  logic cfg_hit;
  logic out_valid_q;

  // The pipeline moves when the output register can take a new word.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr     = cfg_valid_i;

  // Configuration decode and clamping.
  logic [FrameWidthW-1:0]  cfg_w;
  logic [FrameHeightW-1:0] cfg_h;
  assign cfg_w = cfg_data_i[FrameWidthW-1:0];
  assign cfg_h = cfg_data_i[FrameHeightW-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgFrameWidth: begin
          cfg_hit = 1'b1;
          if (cfg_w == '0) begin
            width_d = ColW'(1);
          end else if (32'(cfg_w) > MaxWidth) begin
            width_d = ColW'(MaxWidth);
          end else begin
            width_d = ColW'(cfg_w);
          end
        end
        CfgFrameHeight: begin
          cfg_hit = 1'b1;
          if (cfg_h == '0) begin
            height_d = RowW'(1);
          end else if (32'(cfg_h) > HeightLimit) begin
            height_d = RowW'(HeightLimit);
          end else begin
            height_d = RowW'(cfg_h);
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Position flags of the word being accepted.
  logic at_last_col, at_last_row;
  assign at_last_col = (col_q == width_q);
  assign at_last_row = (row_q == height_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (at_last_col) begin
        col_d = '0;
        row_d = at_last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ColW'(ResetWidth);
      height_q <= RowW'(ResetHeight);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Gray conversion at the input; padding and out-of-image positions read as zero.
  logic [9:0]      rgb_sum;
  logic [PixW-1:0] in_gray;
  assign rgb_sum = 10'(in_word_i.blue) + 10'(in_word_i.green) + 10'(in_word_i.red);
  assign in_gray = (in_word_i.is_padding || at_last_col || at_last_row) ? '0 : div3(rgb_sum);

  // Stage one: the word waits here while the line store read completes.
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_first_col_q;
  logic            s1_row_ge1_q;
  logic            s1_row_ge2_q;
  logic            s1_res_q;
  logic            s1_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q       <= in_gray;
      s1_col_q       <= col_q;
      s1_first_col_q <= (col_q == '0);
      s1_row_ge1_q   <= (row_q != '0);
      s1_row_ge2_q   <= (row_q > RowW'(1));
      s1_res_q       <= (row_q != '0) && (col_q != '0);
      s1_eof_q       <= at_last_col && at_last_row;
    end
  end

  // Line store: upper byte is the row above, lower byte the row two above.
  logic [2*PixW-1:0] line_rd;
  logic [2*PixW-1:0] line_wr;
  logic              line_we;
  logic [PixW-1:0]   row1_pix, row2_pix;

  assign line_we  = adv && s1_valid_q;
  assign line_wr  = {s1_pix_q, line_rd[2*PixW-1:PixW]};
  assign row1_pix = s1_row_ge1_q ? line_rd[2*PixW-1:PixW] : '0;
  assign row2_pix = s1_row_ge2_q ? line_rd[PixW-1:0] : '0;

  b3hs_ram #(
    .Width(2 * PixW),
    .Depth(LineDepth)
  ) u_line_ram (
    .clk_i    (clk_i),
    .wr_en_i  (line_we),
    .wr_addr_i(s1_col_q),
    .wr_data_i(line_wr),
    .rd_en_i  (in_acc),
    .rd_addr_i(col_q),
    .rd_data_o(line_rd)
  );

  // Window: three column cells, the right one fed with the new column, each handing its
  // column to the left neighbor. A word in column zero clears the two older columns.
  win_col_t   new_col;
  win_col_t   cell_in  [3];
  win_col_t   cell_out [3];
  cell_ctrl_t cell_ctrl[3];

  assign new_col = '{top: row2_pix, mid: row1_pix, bot: s1_pix_q};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    if (i == 2) begin : g_right
      assign cell_in[i]   = new_col;
      assign cell_ctrl[i] = '{shift: line_we, clear: 1'b0};
    end else begin : g_inner
      assign cell_in[i]   = cell_out[i+1];
      assign cell_ctrl[i] = '{shift: line_we, clear: s1_first_col_q};
    end
    b3hs_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cell_ctrl[i]),
      .col_i (cell_in[i]),
      .col_o (cell_out[i])
    );
  end

  // Stage two: the window now holds this word's neighborhood.
  logic s2_valid_q;
  logic s2_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_eof_q <= s1_eof_q;
    end
  end

  logic [SumW-1:0] win_sum;
  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      win_sum = win_sum + SumW'(cell_out[i].top) + SumW'(cell_out[i].mid)
              + SumW'(cell_out[i].bot);
    end
  end

  // Stage three: window sum and center pixel.
  logic            s3_valid_q;
  logic [SumW-1:0] s3_sum_q;
  logic [PixW-1:0] s3_gray_q;
  logic            s3_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sum_q  <= win_sum;
      s3_gray_q <= cell_out[1].mid;
      s3_eof_q  <= s2_eof_q;
    end
  end

  // Output register: mean, high-pass and sharpen, all wrapped to eight bits.
  out_word_t       out_word_q;
  out_word_t       out_word_d;
  logic [PixW-1:0] mean;

  assign mean = div9(s3_sum_q);

  always_comb begin
    out_word_d.gray_value     = s3_gray_q;
    out_word_d.mean_value     = mean;
    out_word_d.highpass_value = s3_gray_q - mean;
    out_word_d.sharpen_value  = {s3_gray_q[PixW-2:0], 1'b0} - mean;
    out_word_d.end_of_frame   = s3_eof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/b3hs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the 3x3 box filter block and its bind to the top level.
module b3hs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input b3hs_pkg::out_word_t           out_word_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // The block only holds off input while a result word is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result word");

  // A new result word only appears right after the pipeline has moved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o))
    else $error("result word appeared while the pipeline was held");

endmodule

bind box3x3_highpass_sharpen_top b3hs_checker u_b3hs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the streaming 3x3 box filter with high-pass and sharpen results.
module tb;
  import b3hs_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned IdleLimit   = 2000;
  // Cycles allowed for words that give no result to leave the pipeline.
  localparam int unsigned DrainCycles = 8;
  // Index past the mapped registers; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;
  localparam int unsigned WholeFrame  = 32'hFFFF_FFFF;
  localparam int unsigned RandomWords = 500;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow copy of the filter state.
  logic [PixW-1:0]         line_above  [0:LineDepth-1];
  logic [PixW-1:0]         line_above2 [0:LineDepth-1];
  logic [PixW-1:0]         window      [0:2][0:2];
  int unsigned             row_pos     = 0;
  int unsigned             col_pos     = 0;
  logic [FrameWidthW-1:0]  width_reg   = FrameWidthW'(ResetWidth);
  logic [FrameHeightW-1:0] height_reg  = FrameHeightW'(ResetHeight);

  out_word_t   pending_results[$];
  int unsigned error_count    = 0;
  int unsigned result_count   = 0;
  int unsigned pixels_sent    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned src_gap_max    = 0;
  int unsigned sink_stall_max = 0;
  int unsigned sink_hold_len  = 0;

  box3x3_highpass_sharpen_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HeightLimit) return HeightLimit;
    return 32'(height_reg);
  endfunction

  function automatic in_word_t make_pixel(input logic [PixW-1:0] b, input logic [PixW-1:0] g,
                                          input logic [PixW-1:0] r, input logic pad);
    in_word_t px;
    px.blue       = b;
    px.green      = g;
    px.red        = r;
    px.is_padding = pad;
    return px;
  endfunction

  // Channels lean toward the extremes so that saturated sums show up often.
  function automatic logic [PixW-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_word_t random_pixel();
    return make_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
  endfunction

  // Steps the shadow filter by one accepted pixel word and queues the result it gives.
  task automatic compute_box_result(input in_word_t px);
    int unsigned w, h, r, c, v, sum, mean, gray, k, j;
    out_word_t   res;
    w = active_width();
    h = active_height();
    r = (row_pos > h) ? 0 : row_pos;
    c = (col_pos > w) ? 0 : col_pos;
    v = (32'(px.blue) + 32'(px.green) + 32'(px.red)) / 3;
    // Padding positions read as zero whether or not the word is flagged.
    if (px.is_padding || c == w || r == h) v = 0;

    if (c == 0) begin
      for (k = 0; k < 3; k++) begin
        for (j = 0; j < 3; j++) window[k][j] = '0;
      end
    end
    for (k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = (r >= 2) ? line_above2[c] : '0;
    window[1][2] = (r >= 1) ? line_above[c] : '0;
    window[2][2] = v[PixW-1:0];
    line_above2[c] = line_above[c];
    line_above[c]  = v[PixW-1:0];

    if (r >= 1 && c >= 1) begin
      sum = 0;
      for (k = 0; k < 3; k++) begin
        for (j = 0; j < 3; j++) sum += 32'(window[k][j]);
      end
      mean = sum / 9;
      gray = 32'(window[1][1]);
      res.gray_value     = 8'(gray);
      res.mean_value     = 8'(mean);
      res.highpass_value = 8'(gray - mean);
      res.sharpen_value  = 8'(2 * gray - mean);
      res.end_of_frame   = (r == h && c == w);
      pending_results.push_back(res);
    end

    c++;
    if (c > w) begin
      c = 0;
      r++;
      if (r > h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic send_pixel(input in_word_t px);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    compute_box_result(px);
  endtask

  // Sends raster positions first .. first+count-1 of the current frame with random pixels.
  // Padding positions are flagged, except for a share of noise where the flag is flipped.
  task automatic send_frame(input int unsigned first, input int unsigned count,
                            input int unsigned noise_pct);
    int unsigned cols, rows, k;
    in_word_t    px;
    cols = active_width() + 1;
    rows = active_height() + 1;
    for (k = first; k < cols * rows && k - first < count; k++) begin
      px = random_pixel();
      px.is_padding = (k % cols == cols - 1) || (k / cols == rows - 1);
      if ($urandom_range(0, 99) < noise_pct) px.is_padding = ~px.is_padding;
      send_pixel(px);
    end
  endtask

  // Stops input and waits until every queued result has left, plus the pipeline depth.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    drain_block();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    // Only the mapped registers restart the frame.
    if (idx == CfgFrameWidth || idx == CfgFrameHeight) begin
      if (idx == CfgFrameWidth) width_reg = data[FrameWidthW-1:0];
      else height_reg = data[FrameHeightW-1:0];
      row_pos = 0;
      col_pos = 0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("error: result %0d %s: got 0x%0h, expected 0x%0h", result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word", 32'(got.gray_value), 0);
    end else begin
      want = pending_results.pop_front();
      if (got.gray_value !== want.gray_value)
        report_mismatch("gray_value", 32'(got.gray_value), 32'(want.gray_value));
      if (got.mean_value !== want.mean_value)
        report_mismatch("mean_value", 32'(got.mean_value), 32'(want.mean_value));
      if (got.highpass_value !== want.highpass_value)
        report_mismatch("highpass_value", 32'(got.highpass_value),
                        32'(want.highpass_value));
      if (got.sharpen_value !== want.sharpen_value)
        report_mismatch("sharpen_value", 32'(got.sharpen_value), 32'(want.sharpen_value));
      if (got.end_of_frame !== want.end_of_frame)
        report_mismatch("end_of_frame", 32'(got.end_of_frame), 32'(want.end_of_frame));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_word_o);
  end

  // The sink draws a stall length per result; a requested hold overrides one draw.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      if (sink_hold_len != 0) begin
        hold = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        hold = $urandom_range(0, sink_stall_max);
      end
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // At the reset size the first row gives no results at all.
  task automatic test_reset_size();
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd170, 8'd85, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 1'b0));
  endtask

  // A 3x2 image: full-scale neighbors around dark pixels make both high-pass and sharpen
  // wrap, a flagged real pixel reads as zero, and unflagged padding positions still read
  // as zero.
  task automatic test_small_frame();
    write_register(CfgFrameWidth, 13'd3);
    write_register(CfgFrameHeight, 13'd2);
    src_gap_max    = 2;
    sink_stall_max = 2;
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd9, 8'd9, 8'd9, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 1'b1));
    send_pixel(make_pixel(8'd77, 8'd77, 8'd77, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 1'b0));
  endtask

  // Zero sizes read as one pixel; the upper data bits above the width field are dropped.
  task automatic test_zero_size();
    write_register(CfgFrameWidth, 13'd0);
    write_register(CfgFrameHeight, 13'd0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd1, 8'd1, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
    write_register(CfgFrameWidth, 13'h1801);
    send_pixel(make_pixel(8'd3, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
  endtask

  // The start of a frame at the widest row; the next register write breaks it off.
  task automatic test_widest_row();
    src_gap_max    = 0;
    sink_stall_max = 0;
    write_register(CfgFrameWidth, CfgDataW'(MaxWidth));
    write_register(CfgFrameHeight, 13'd1);
    send_frame(0, 200, 0);
  endtask

  // The start of a frame at the tallest height with one-pixel rows, so every second word
  // steps the row count.
  task automatic test_tallest_frame();
    write_register(CfgFrameWidth, 13'd1);
    write_register(CfgFrameHeight, CfgDataW'(HeightLimit));
    send_frame(0, 150, 0);
  endtask

  // A write to an unmapped index in the middle of a frame must not restart it.
  task automatic test_spare_index();
    src_gap_max    = 3;
    sink_stall_max = 3;
    write_register(CfgFrameWidth, 13'd4);
    write_register(CfgFrameHeight, 13'd3);
    send_frame(0, 12, 0);
    write_register(CfgSpare, CfgDataW'($urandom_range(0, 8191)));
    send_frame(12, WholeFrame, 0);
  endtask

  // The sink holds off for a long stretch while the source keeps offering words, so the
  // pipeline fills and stalls its input; two frames back to back also cover frame wrap.
  task automatic test_backpressure();
    src_gap_max    = 0;
    sink_stall_max = 0;
    write_register(CfgFrameWidth, 13'd8);
    write_register(CfgFrameHeight, 13'd4);
    sink_hold_len = 150;
    send_frame(0, WholeFrame, 0);
    send_frame(0, WholeFrame, 0);
  endtask

  // Random sizes, mostly small; oversize registers are tried with cut-short frames.
  task automatic test_random_frames();
    int unsigned start_count, frames, f, mode, w_data, h_data;
    bit          cut;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RandomWords) begin
      mode = $urandom_range(0, 9);
      cut  = 1'b0;
      case (mode)
        0: begin
          w_data = $urandom_range(MaxWidth + 1, 2047);
          h_data = $urandom_range(1, 3);
          cut    = 1'b1;
        end
        1: begin
          w_data = $urandom_range(1, 4);
          h_data = $urandom_range(HeightLimit + 1, 8191);
          cut    = 1'b1;
        end
        2, 3: begin
          w_data = $urandom_range(13, 40);
          h_data = $urandom_range(1, 4);
        end
        default: begin
          w_data = $urandom_range(1, 12);
          h_data = $urandom_range(1, 6);
        end
      endcase
      case ($urandom_range(0, 2))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_max = 0;
        1: sink_stall_max = 3;
        default: sink_stall_max = 12;
      endcase
      if ($urandom_range(0, 1)) begin
        write_register(CfgFrameWidth, CfgDataW'(w_data));
        write_register(CfgFrameHeight, CfgDataW'(h_data));
      end else begin
        write_register(CfgFrameHeight, CfgDataW'(h_data));
        write_register(CfgFrameWidth, CfgDataW'(w_data));
      end
      if (cut) begin
        send_frame(0, $urandom_range(10, 40), 5);
      end else begin
        frames = $urandom_range(1, 3);
        for (f = 0; f < frames; f++) begin
          // Now and then the last frame is broken off by the next register write.
          if (f == frames - 1 && $urandom_range(0, 4) == 0)
            send_frame(0, $urandom_range(1, 30), 5);
          else
            send_frame(0, WholeFrame, 5);
        end
      end
    end
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < LineDepth; i++) begin
      line_above[i]  = '0;
      line_above2[i] = '0;
    end
    for (i = 0; i < 9; i++) window[i / 3][i % 3] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size();
    test_small_frame();
    test_zero_size();
    test_spare_index();
    test_backpressure();
    test_widest_row();
    test_tallest_frame();
    test_random_frames();

    drain_block();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
